>>> rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants of the AA/55 framed target packet parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int COUNTER_WIDTH = 32;
  localparam int NUM_CNT       = 7;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  // item commands (in_tuser)
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_USABLE_TO   = 2'd1;
  localparam logic [1:0] CFG_LINK_TO     = 2'd2;

  // frame status codes
  localparam logic [2:0] STS_NONE   = 3'd0;
  localparam logic [2:0] STS_SUMERR = 3'd1;
  localparam logic [2:0] STS_REPEAT = 3'd2;
  localparam logic [2:0] STS_NOTGT  = 3'd3;
  localparam logic [2:0] STS_RANGE  = 3'd4;
  localparam logic [2:0] STS_VALID  = 3'd5;

  // event counter indexes
  localparam logic [2:0] CNT_GOOD   = 3'd0;
  localparam logic [2:0] CNT_VALID  = 3'd1;
  localparam logic [2:0] CNT_SUMERR = 3'd2;
  localparam logic [2:0] CNT_REPEAT = 3'd3;
  localparam logic [2:0] CNT_LOST   = 3'd4;
  localparam logic [2:0] CNT_BREAK  = 3'd5;
  localparam logic [2:0] CNT_RANGE  = 3'd6;

  localparam logic [7:0] SYNC_0      = 8'hAA;
  localparam logic [7:0] SYNC_1      = 8'h55;
  localparam logic [7:0] FLAG_TARGET = 8'h01;
  localparam logic [7:0] SEQ_HALF    = 8'd128;

  // result beat layout in out_tdata
  localparam int OUT_TDATA_W = 80;
  localparam int OFS_STATUS  = 0;
  localparam int OFS_VALID   = 19;
  localparam int OFS_USABLE  = 44;

  // completed frame as seen by the parser
  typedef struct packed {
    logic       done;
    logic       sum_ok;
    logic       drop;
    logic [7:0] flags;
    logic [7:0] seq;
    logic [15:0] x;
    logic [7:0] width;
  } frame_t;

  // evaluation result, values after the current beat
  typedef struct packed {
    logic [2:0]  status;
    logic        good_now;
    logic        valid_now;
    logic        good_nz;
    logic [15:0] x;
    logic        valid;
    logic [7:0]  flags;
    logic [7:0]  width;
    logic [7:0]  seq;
  } eval_t;

endpackage

>>> rtl/sfp_byte_parser.sv
// ----------------------------------------------------------------------------
// sfp_byte_parser
// Sync hunt (AA, 55), byte collection and running 8-bit sum.
// ----------------------------------------------------------------------------
module sfp_byte_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_en,
  input  logic [7:0]      byte_in,
  output sfp_pkg::frame_t frame
);

  localparam logic [1:0] ST_WAIT_AA = 2'd0;
  localparam logic [1:0] ST_WAIT_55 = 2'd1;
  localparam logic [1:0] ST_COLLECT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] bytes_r [0:4];   // frame bytes 2..6
  logic [2:0] wr_sel;
  logic       wr_en;
  logic       done;
  logic       drop;

  assign wr_sel = idx_r - 3'd2;
  assign wr_en  = byte_en && (state_r == ST_COLLECT) && (idx_r >= 3'd2) && (idx_r <= 3'd6);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    done      = 1'b0;
    drop      = 1'b0;
    case (state_r)
      ST_WAIT_AA: begin
        if (byte_in == sfp_pkg::SYNC_0) begin
          sum_nxt   = byte_in;
          state_nxt = ST_WAIT_55;
        end
      end
      ST_WAIT_55: begin
        if (byte_in == sfp_pkg::SYNC_1) begin
          sum_nxt   = sum_r + byte_in;
          idx_nxt   = 3'd2;
          state_nxt = ST_COLLECT;
        end else if (byte_in != sfp_pkg::SYNC_0) begin
          state_nxt = ST_WAIT_AA;
        end
      end
      ST_COLLECT: begin
        if (idx_r == 3'd7) begin
          done      = 1'b1;
          state_nxt = ST_WAIT_AA;
          idx_nxt   = 3'd0;
        end else begin
          sum_nxt = sum_r + byte_in;
          idx_nxt = idx_r + 3'd1;
        end
      end
      default: begin
        state_nxt = ST_WAIT_AA;
        idx_nxt   = 3'd0;
        drop      = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT_AA;
      idx_r   <= 3'd0;
      sum_r   <= 8'd0;
    end else if (byte_en) begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_sel] <= byte_in;
    end
  end

  // last byte is the checksum, compared against the sum of bytes 0..6
  always_comb begin
    frame.done   = byte_en && done;
    frame.drop   = byte_en && drop;
    frame.sum_ok = (sum_r == byte_in);
    frame.flags  = bytes_r[0];
    frame.seq    = bytes_r[1];
    frame.x      = {bytes_r[3], bytes_r[2]};
    frame.width  = bytes_r[4];
  end

endmodule

>>> rtl/sfp_frame_eval.sv
// ----------------------------------------------------------------------------
// sfp_frame_eval
// Frame checks, sequence tracking, stored target values and event counters.
// ----------------------------------------------------------------------------
module sfp_frame_eval (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_en,
  input  sfp_pkg::frame_t frame,
  input  logic            rd_en,
  input  logic [7:0]      rd_idx,
  input  logic [15:0]     image_width,
  input  logic [31:0]     ms_time,
  output sfp_pkg::eval_t  ev,
  output logic [31:0]     last_good_time,
  output logic [31:0]     last_valid_time,
  output logic [31:0]     cnt_value
);

  logic        have_seq_r, have_seq_nxt;
  logic [7:0]  last_seq_r, last_seq_nxt;
  logic [15:0] x_r, x_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  width_r, width_nxt;
  logic [31:0] lgt_r, lgt_nxt;
  logic [31:0] lvt_r, lvt_nxt;
  sfp_pkg::cnt_t cnt_r   [sfp_pkg::NUM_CNT];
  sfp_pkg::cnt_t cnt_nxt [sfp_pkg::NUM_CNT];
  sfp_pkg::cnt_t cnt_inc [sfp_pkg::NUM_CNT];
  logic [7:0]  delta;
  logic [2:0]  status;
  logic        good_now;
  logic        valid_now;

  assign delta = frame.seq - last_seq_r;

  always_comb begin
    have_seq_nxt = have_seq_r;
    last_seq_nxt = last_seq_r;
    x_nxt        = x_r;
    valid_nxt    = valid_r;
    flags_nxt    = flags_r;
    width_nxt    = width_r;
    lgt_nxt      = lgt_r;
    lvt_nxt      = lvt_r;
    status       = sfp_pkg::STS_NONE;
    good_now     = 1'b0;
    valid_now    = 1'b0;
    for (int i = 0; i < sfp_pkg::NUM_CNT; i++) begin
      cnt_inc[i] = '0;
    end

    if (frame.drop) begin
      have_seq_nxt = 1'b0;
    end

    if (frame.done) begin
      if (!frame.sum_ok) begin
        status                      = sfp_pkg::STS_SUMERR;
        cnt_inc[sfp_pkg::CNT_SUMERR] = sfp_pkg::cnt_t'(1);
      end else begin
        good_now                   = 1'b1;
        lgt_nxt                    = ms_time;
        cnt_inc[sfp_pkg::CNT_GOOD] = sfp_pkg::cnt_t'(1);
        if (have_seq_r && (delta == 8'd0)) begin
          // repeated frame: counted as good, stored values untouched
          status                       = sfp_pkg::STS_REPEAT;
          cnt_inc[sfp_pkg::CNT_REPEAT] = sfp_pkg::cnt_t'(1);
        end else begin
          if (have_seq_r && (delta != 8'd1)) begin
            if (delta < sfp_pkg::SEQ_HALF) begin
              cnt_inc[sfp_pkg::CNT_LOST] = sfp_pkg::cnt_t'(delta - 8'd1);
            end else begin
              cnt_inc[sfp_pkg::CNT_BREAK] = sfp_pkg::cnt_t'(1);
            end
          end
          last_seq_nxt = frame.seq;
          have_seq_nxt = 1'b1;
          flags_nxt    = frame.flags;
          width_nxt    = frame.width;
          if ((frame.flags & sfp_pkg::FLAG_TARGET) == 8'd0) begin
            valid_nxt = 1'b0;
            status    = sfp_pkg::STS_NOTGT;
          end else if (frame.x >= image_width) begin
            valid_nxt                   = 1'b0;
            status                      = sfp_pkg::STS_RANGE;
            cnt_inc[sfp_pkg::CNT_RANGE] = sfp_pkg::cnt_t'(1);
          end else begin
            x_nxt                       = frame.x;
            valid_nxt                   = 1'b1;
            valid_now                   = 1'b1;
            lvt_nxt                     = ms_time;
            status                      = sfp_pkg::STS_VALID;
            cnt_inc[sfp_pkg::CNT_VALID] = sfp_pkg::cnt_t'(1);
          end
        end
      end
    end

    for (int i = 0; i < sfp_pkg::NUM_CNT; i++) begin
      cnt_nxt[i] = cnt_r[i] + cnt_inc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_seq_r <= 1'b0;
      last_seq_r <= 8'd0;
      x_r        <= 16'd0;
      valid_r    <= 1'b0;
      flags_r    <= 8'd0;
      width_r    <= 8'd0;
      lgt_r      <= 32'd0;
      lvt_r      <= 32'd0;
      for (int i = 0; i < sfp_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (item_en) begin
      have_seq_r <= have_seq_nxt;
      last_seq_r <= last_seq_nxt;
      x_r        <= x_nxt;
      valid_r    <= valid_nxt;
      flags_r    <= flags_nxt;
      width_r    <= width_nxt;
      lgt_r      <= lgt_nxt;
      lvt_r      <= lvt_nxt;
      for (int i = 0; i < sfp_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_comb begin
    ev.status    = status;
    ev.good_now  = good_now;
    ev.valid_now = valid_now;
    ev.good_nz   = (cnt_nxt[sfp_pkg::CNT_GOOD] != '0);
    ev.x         = x_nxt;
    ev.valid     = valid_nxt;
    ev.flags     = flags_nxt;
    ev.width     = width_nxt;
    ev.seq       = last_seq_nxt;
  end

  assign last_good_time  = lgt_r;
  assign last_valid_time = lvt_r;

  // a read beat never carries a frame, so the current counts are the answer
  always_comb begin
    cnt_value = 32'd0;
    if (rd_en && (rd_idx < 8'(sfp_pkg::NUM_CNT))) begin
      cnt_value = 32'(cnt_r[rd_idx[2:0]]);
    end
  end

endmodule

>>> rtl/sync_framed_target_packet_parser.sv
// ----------------------------------------------------------------------------
// sync_framed_target_packet_parser
// AA/55 framed target packet parser with 8-bit sum checksum and timeouts.
// ----------------------------------------------------------------------------
// Each input beat is a received byte, a one-millisecond tick or a counter
// read (command in in_tuser), and each yields exactly one result beat in the
// cycle after acceptance. The byte parser, frame checks, counters and timeout
// compares all settle between the input port and the result register, so a
// beat is accepted every cycle while the result register is empty or being
// drained. out_tlast marks the byte that completed an 8-byte frame; out_tdata
// then carries its status. Config writes are taken in any cycle and should
// only be issued while the block is idle.
module sync_framed_target_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [2:0] frame_status, [18:3] target_x,
                                  // [19] target_valid, [27:20] frame_flags,
                                  // [35:28] target_width, [43:36] sequence_res,
                                  // [44] usable, [45] link_alive,
                                  // [77:46] counter_value, [79:78] zero
  output logic        out_tlast,  // frame_done
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        accept;
  logic [1:0]  cmd;
  logic [7:0]  data;
  logic [15:0] image_width_r;
  logic [31:0] usable_to_r;
  logic [31:0] link_to_r;
  logic [31:0] ms_time_r, ms_time_nxt;
  logic [31:0] last_good_time;
  logic [31:0] last_valid_time;
  logic [31:0] cnt_value;
  logic        usable;
  logic        alive;
  logic        out_valid_r;
  logic        out_last_r;
  logic [79:0] out_data_r;

  sfp_pkg::frame_t frame;
  sfp_pkg::eval_t  ev;

  assign cmd       = in_tuser;
  assign data      = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  sfp_byte_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (accept && (cmd == sfp_pkg::CMD_BYTE)),
    .byte_in (data),
    .frame   (frame)
  );

  sfp_frame_eval u_eval (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_en         (accept),
    .frame           (frame),
    .rd_en           (cmd == sfp_pkg::CMD_READ),
    .rd_idx          (data),
    .image_width     (image_width_r),
    .ms_time         (ms_time_r),
    .ev              (ev),
    .last_good_time  (last_good_time),
    .last_valid_time (last_valid_time),
    .cnt_value       (cnt_value)
  );

  assign ms_time_nxt = (cmd == sfp_pkg::CMD_TICK) ? ms_time_r + 32'd1 : ms_time_r;

  // a frame stamped on this beat has age zero
  assign usable = ev.valid &&
                  (ev.valid_now ? (usable_to_r != 32'd0)
                                : ((ms_time_nxt - last_valid_time) < usable_to_r));
  assign alive  = ev.good_nz &&
                  (ev.good_now ? (link_to_r != 32'd0)
                               : ((ms_time_nxt - last_good_time) < link_to_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= 16'd320;
      usable_to_r   <= 32'd200;
      link_to_r     <= 32'd500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfp_pkg::CFG_IMAGE_WIDTH: image_width_r <= cfg_data[15:0];
        sfp_pkg::CFG_USABLE_TO:   usable_to_r   <= cfg_data;
        sfp_pkg::CFG_LINK_TO:     link_to_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_time_r   <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ms_time_r <= ms_time_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_last_r <= frame.done;
      out_data_r <= {2'b00, cnt_value, alive, usable, ev.seq, ev.width, ev.flags,
                     ev.valid, ev.x, ev.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks of the packet parser result stream.
// ----------------------------------------------------------------------------
module sfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic        out_tlast
);

  logic [2:0] status;
  logic       tgt_valid;
  logic       usable;

  assign status    = out_tdata[sfp_pkg::OFS_STATUS +: 3];
  assign tgt_valid = out_tdata[sfp_pkg::OFS_VALID];
  assign usable    = out_tdata[sfp_pkg::OFS_USABLE];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // status only on the frame-completing beat
  a_status_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> status == sfp_pkg::STS_NONE)
    else $error("status without frame done");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> status != sfp_pkg::STS_NONE && status <= sfp_pkg::STS_VALID)
    else $error("frame done with bad status");

  // usable needs a stored valid target, and a valid frame leaves one stored
  a_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (usable || (out_tlast && status == sfp_pkg::STS_VALID)) |-> tgt_valid)
    else $error("usable or valid frame without stored target");

endmodule

bind sync_framed_target_packet_parser sfp_checker u_sfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the AA/55 target packet parser. Bytes, millisecond
// ticks and counter reads are driven with random idling on both ports; each
// result beat is compared field by field against an in-bench parser model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_PERIOD = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {HUNT_AA, HUNT_55, GATHER} sync_state_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic          done;
    logic [2:0]    status;
    logic [15:0]   x;
    logic          valid;
    logic [7:0]    flags;
    logic [7:0]    width;
    logic [7:0]    seq;
    logic          usable;
    logic          alive;
    sfp_pkg::cnt_t count;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sync_framed_target_packet_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // parser model state
  sync_state_t   sync_state;
  logic [2:0]    byte_pos;
  logic [7:0]    frame_buf [8];
  logic [7:0]    sum_acc;
  logic          seq_seen;
  logic [7:0]    prev_seq;
  logic [15:0]   tgt_x;
  logic          tgt_valid;
  logic [7:0]    tgt_flags;
  logic [7:0]    tgt_width;
  logic [31:0]   now_ms;
  logic [31:0]   good_ms;
  logic [31:0]   tgt_ms;
  sfp_pkg::cnt_t event_cnt [sfp_pkg::NUM_CNT];
  logic [15:0]   img_width_reg;
  logic [31:0]   usable_to_reg;
  logic [31:0]   link_to_reg;

  beat_t         pending_beats [$];
  parse_result_t expected_results [$];

  int unsigned beats_queued = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned frame_tally [6] = '{default: 0};
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_request = 0;
  int unsigned hold_served = 0;
  int unsigned stall_cycles = 0;
  logic [7:0]  gen_seq = '0;

  function automatic void reset_parser_model();
    sync_state = HUNT_AA;
    byte_pos = '0;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    sum_acc = '0;
    seq_seen = 1'b0;
    prev_seq = '0;
    tgt_x = '0;
    tgt_valid = 1'b0;
    tgt_flags = '0;
    tgt_width = '0;
    now_ms = '0;
    good_ms = '0;
    tgt_ms = '0;
    foreach (event_cnt[i]) event_cnt[i] = '0;
    img_width_reg = 16'd320;
    usable_to_reg = 32'd200;
    link_to_reg = 32'd500;
  endfunction

  // advances the model by one accepted beat and returns the result it causes
  function automatic parse_result_t advance_parser(logic [1:0] cmd, logic [7:0] data);
    parse_result_t r;
    logic [7:0]  delta;
    logic [15:0] x;
    r = '0;
    case (cmd)
      sfp_pkg::CMD_BYTE: begin
        case (sync_state)
          HUNT_AA: begin
            if (data == sfp_pkg::SYNC_0) begin
              frame_buf[0] = data;
              sum_acc = data;
              sync_state = HUNT_55;
            end
          end
          HUNT_55: begin
            if (data == sfp_pkg::SYNC_1) begin
              frame_buf[1] = data;
              sum_acc += data;
              byte_pos = 3'd2;
              sync_state = GATHER;
            end else if (data != sfp_pkg::SYNC_0) begin
              sync_state = HUNT_AA;
            end
          end
          default: begin
            frame_buf[byte_pos] = data;
            if (byte_pos == 3'd7) begin
              r.done = 1'b1;
              sync_state = HUNT_AA;
              byte_pos = '0;
              if (sum_acc != frame_buf[7]) begin
                event_cnt[sfp_pkg::CNT_SUMERR]++;
                r.status = sfp_pkg::STS_SUMERR;
              end else begin
                event_cnt[sfp_pkg::CNT_GOOD]++;
                good_ms = now_ms;
                delta = frame_buf[3] - prev_seq;
                if (seq_seen && delta == 8'd0) begin
                  event_cnt[sfp_pkg::CNT_REPEAT]++;
                  r.status = sfp_pkg::STS_REPEAT;
                end else begin
                  // a gap still accepts the frame
                  if (seq_seen && delta != 8'd1) begin
                    if (delta < sfp_pkg::SEQ_HALF) begin
                      event_cnt[sfp_pkg::CNT_LOST] += sfp_pkg::cnt_t'(delta) - 1;
                    end else begin
                      event_cnt[sfp_pkg::CNT_BREAK]++;
                    end
                  end
                  prev_seq = frame_buf[3];
                  seq_seen = 1'b1;
                  tgt_flags = frame_buf[2];
                  tgt_width = frame_buf[6];
                  x = {frame_buf[5], frame_buf[4]};
                  if ((frame_buf[2] & sfp_pkg::FLAG_TARGET) == 8'd0) begin
                    tgt_valid = 1'b0;
                    r.status = sfp_pkg::STS_NOTGT;
                  end else if (x >= img_width_reg) begin
                    tgt_valid = 1'b0;
                    event_cnt[sfp_pkg::CNT_RANGE]++;
                    r.status = sfp_pkg::STS_RANGE;
                  end else begin
                    tgt_x = x;
                    tgt_valid = 1'b1;
                    tgt_ms = now_ms;
                    event_cnt[sfp_pkg::CNT_VALID]++;
                    r.status = sfp_pkg::STS_VALID;
                  end
                end
              end
            end else begin
              sum_acc += data;
              byte_pos++;
            end
          end
        endcase
      end
      sfp_pkg::CMD_TICK: now_ms++;
      sfp_pkg::CMD_READ: if (data < sfp_pkg::NUM_CNT) r.count = event_cnt[data];
      default: ;
    endcase
    r.x = tgt_x;
    r.valid = tgt_valid;
    r.flags = tgt_flags;
    r.width = tgt_width;
    r.seq = prev_seq;
    r.usable = tgt_valid && ((now_ms - tgt_ms) < usable_to_reg);
    r.alive = (event_cnt[sfp_pkg::CNT_GOOD] != 0) && ((now_ms - good_ms) < link_to_reg);
    if (r.done) frame_tally[r.status]++;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    parse_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, tdata %h tlast %b",
               $time, out_tdata, out_tlast);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("frame_done", want.done, out_tlast);
      check_field("frame_status", want.status, out_tdata[2:0]);
      check_field("target_x", want.x, out_tdata[18:3]);
      check_field("target_valid", want.valid, out_tdata[19]);
      check_field("frame_flags", want.flags, out_tdata[27:20]);
      check_field("target_width", want.width, out_tdata[35:28]);
      check_field("sequence", want.seq, out_tdata[43:36]);
      check_field("usable", want.usable, out_tdata[44]);
      check_field("link_alive", want.alive, out_tdata[45]);
      check_field("counter_value", want.count, out_tdata[77:46]);
      check_field("tdata pad", '0, out_tdata[79:78]);
    end
  endtask

  // input side: predicts on every accepted beat, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(advance_parser(in_tuser, in_tdata));
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0 && $urandom_range(99) < send_idle_pct) begin
          send_gap = $urandom_range(15);
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_tuser <= pending_beats[0].cmd;
          in_tdata <= pending_beats[0].data;
          void'(pending_beats.pop_front());
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: checks accepted beats and throttles out_tready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (hold_request != hold_served) begin
        hold_served = hold_request;
        recv_gap = LONG_HOLD;
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        recv_gap = $urandom_range(15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sfp_pkg::CFG_IMAGE_WIDTH: img_width_reg = value[15:0];
      sfp_pkg::CFG_USABLE_TO:   usable_to_reg = value;
      sfp_pkg::CFG_LINK_TO:     link_to_reg = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  task automatic queue_beat(input logic [1:0] cmd, input logic [7:0] data);
    beat_t b;
    b.cmd = cmd;
    b.data = data;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] flags, input logic [7:0] seq,
                             input logic [15:0] x, input logic [7:0] width,
                             input bit corrupt, input int unsigned extra_sync);
    logic [7:0] body [7];
    logic [7:0] sum;
    body = '{sfp_pkg::SYNC_0, sfp_pkg::SYNC_1, flags, seq, x[7:0], x[15:8], width};
    sum = '0;
    repeat (extra_sync) queue_beat(sfp_pkg::CMD_BYTE, sfp_pkg::SYNC_0);
    foreach (body[i]) begin
      queue_beat(sfp_pkg::CMD_BYTE, body[i]);
      sum += body[i];
    end
    queue_beat(sfp_pkg::CMD_BYTE, corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
  endtask

  // mostly well-formed frames with random content, mixed with ticks, reads,
  // unused commands, line noise and broken sync sequences
  task automatic queue_random(input int unsigned count, input int unsigned tick_max);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  flags;
    logic [15:0] x;
    stop_at = beats_queued + count;
    while (beats_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 52) begin
        flags = 8'($urandom);
        if ($urandom_range(3) != 0) flags[0] = 1'b1;
        n = $urandom_range(99);
        if (n >= 10)
          gen_seq += (n < 70) ? 8'd1 :
                     (n < 85) ? 8'($urandom_range(2, 127)) : 8'($urandom_range(128, 255));
        case ($urandom_range(5))
          0: x = 16'h0000;
          1: x = 16'hFFFF;
          2: x = img_width_reg - 16'd1;
          3: x = img_width_reg;
          default: x = 16'($urandom);
        endcase
        queue_frame(flags, gen_seq, x, 8'($urandom), $urandom_range(99) < 12,
                    ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      end else if (pick < 62) begin
        repeat ($urandom_range(1, tick_max)) queue_beat(sfp_pkg::CMD_TICK, 8'($urandom));
      end else if (pick < 72) begin
        queue_beat(sfp_pkg::CMD_READ,
                   ($urandom_range(4) != 0) ? 8'($urandom_range(0, sfp_pkg::NUM_CNT - 1))
                                            : 8'($urandom_range(sfp_pkg::NUM_CNT, 255)));
      end else if (pick < 76) begin
        queue_beat(CMD_UNUSED, 8'($urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) queue_beat(sfp_pkg::CMD_BYTE, 8'($urandom));
      end else if (pick < 93) begin
        // truncated frame, the following bytes get pulled into it
        queue_beat(sfp_pkg::CMD_BYTE, sfp_pkg::SYNC_0);
        queue_beat(sfp_pkg::CMD_BYTE, sfp_pkg::SYNC_1);
        repeat ($urandom_range(0, 5)) queue_beat(sfp_pkg::CMD_BYTE, 8'($urandom));
      end else begin
        queue_beat(sfp_pkg::CMD_BYTE, sfp_pkg::SYNC_0);
        queue_beat(sfp_pkg::CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  initial begin
    reset_parser_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset
    send_idle_pct = 10;
    recv_idle_pct = 10;
    queue_beat(CMD_UNUSED, 8'hFF);
    queue_beat(sfp_pkg::CMD_READ, 8'd7);
    queue_beat(sfp_pkg::CMD_READ, 8'hFF);
    queue_beat(sfp_pkg::CMD_TICK, 8'h00);
    queue_beat(sfp_pkg::CMD_BYTE, 8'h00);
    // repeated AA ahead of the 55, then the same sequence number twice
    queue_frame(sfp_pkg::FLAG_TARGET, 8'hFF, 16'h0000, 8'hFF, 1'b0, 1);
    queue_frame(sfp_pkg::FLAG_TARGET, 8'hFF, 16'hFFFF, 8'h00, 1'b0, 0);
    queue_beat(sfp_pkg::CMD_READ, {5'd0, sfp_pkg::CNT_REPEAT});
    queue_random(240, 8);
    wait_drained();

    // lowest settings
    write_reg(sfp_pkg::CFG_IMAGE_WIDTH, 32'd1);
    write_reg(sfp_pkg::CFG_USABLE_TO, 32'd1);
    write_reg(sfp_pkg::CFG_LINK_TO, 32'd1);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 12;
    queue_random(220, 3);
    wait_drained();

    // highest settings; receiver holds off while the sender keeps offering
    write_reg(sfp_pkg::CFG_IMAGE_WIDTH, 32'hFFFF_FFFF);
    write_reg(sfp_pkg::CFG_USABLE_TO, 32'hFFFF_FFFF);
    write_reg(sfp_pkg::CFG_LINK_TO, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, $urandom);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 8;
    hold_request++;
    queue_random(260, 6);
    wait_drained();

    // short timeouts with long tick bursts
    write_reg(sfp_pkg::CFG_IMAGE_WIDTH, {16'($urandom), 16'($urandom_range(8, 1200))});
    write_reg(sfp_pkg::CFG_USABLE_TO, $urandom_range(2, 40));
    write_reg(sfp_pkg::CFG_LINK_TO, $urandom_range(5, 80));
    @(negedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 0;
    queue_random(300, 40);
    wait_drained();

    // back to defaults, full rate on both sides
    write_reg(sfp_pkg::CFG_IMAGE_WIDTH, 32'd320);
    write_reg(sfp_pkg::CFG_USABLE_TO, 32'd200);
    write_reg(sfp_pkg::CFG_LINK_TO, 32'd500);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(260, 12);
    wait_drained();
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("covered %0d input beats, %0d register writes, %0d completed frames",
             beats_queued, cfg_writes,
             frame_tally[sfp_pkg::STS_SUMERR] + frame_tally[sfp_pkg::STS_REPEAT] +
             frame_tally[sfp_pkg::STS_NOTGT] + frame_tally[sfp_pkg::STS_RANGE] +
             frame_tally[sfp_pkg::STS_VALID]);
    $display("frames: %0d bad sum, %0d repeat, %0d no target, %0d out of range, %0d valid",
             frame_tally[sfp_pkg::STS_SUMERR], frame_tally[sfp_pkg::STS_REPEAT],
             frame_tally[sfp_pkg::STS_NOTGT], frame_tally[sfp_pkg::STS_RANGE],
             frame_tally[sfp_pkg::STS_VALID]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
